[hdl/nearest_site_distance_binner_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SITE_DISTANCE_BINNER_UNIT_ASSERT_SVH
`define NEAREST_SITE_DISTANCE_BINNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NSDB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NSDB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSDB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define NSDB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/nsdb_pkg.sv]
// ----------------------------------------------------------------------------
// nsdb_pkg
// Widths, codes and shared types of the nearest site distance binner.
// ----------------------------------------------------------------------------
package nsdb_pkg;

    localparam int MAX_SITES    = 1024;
    localparam int SITE_AW      = $clog2(MAX_SITES);
    localparam int SCAN_CW      = SITE_AW + 1;
    localparam int SITE_COUNT_W = 11;
    localparam int COORD_W      = 24;
    localparam int MAG_W        = COORD_W + 1;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int LIMIT_W      = 23;
    localparam int CNT_W        = 32;
    localparam int BIN_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 23;
    localparam int IN_TDATA_W   = 64;
    localparam int IN_USED_W    = SITE_AW + 2 * COORD_W;
    localparam int OUT_TDATA_W  = 168;
    localparam int OUT_USED_W   = BIN_W + 5 * CNT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SITE_COUNT = 2'd0,
        CFG_NEAR_LIMIT = 2'd1,
        CFG_MID_LIMIT  = 2'd2,
        CFG_FAR_LIMIT  = 2'd3
    } cfg_idx_t;

    typedef enum logic [BIN_W-1:0] {
        BIN_NEAR   = 2'd0,
        BIN_MID    = 2'd1,
        BIN_FAR    = 2'd2,
        BIN_BEYOND = 2'd3
    } bin_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic s1_valid;
        logic out_valid;
    } sq_stat_t;

    typedef struct packed {
        logic [CNT_W-1:0] query;
        logic [CNT_W-1:0] beyond;
        logic [CNT_W-1:0] far;
        logic [CNT_W-1:0] mid;
        logic [CNT_W-1:0] near;
    } counts_t;

endpackage

[hdl/nsdb_site_ram.sv]
// ----------------------------------------------------------------------------
// nsdb_site_ram
// Site coordinate table, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nsdb_site_ram (
    input  logic                               clk,
    input  logic                               we,
    input  logic [nsdb_pkg::SITE_AW-1:0]       waddr,
    input  logic [2*nsdb_pkg::COORD_W-1:0]     wdata,
    input  logic                               re,
    input  logic [nsdb_pkg::SITE_AW-1:0]       raddr,
    output logic [2*nsdb_pkg::COORD_W-1:0]     rdata
);

    logic [2*nsdb_pkg::COORD_W-1:0] mem [nsdb_pkg::MAX_SITES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/nsdb_sq_unit.sv]
// ----------------------------------------------------------------------------
// nsdb_sq_unit
// Shared sum-of-squares unit: two registered squarers and a registered adder.
// ----------------------------------------------------------------------------
module nsdb_sq_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [nsdb_pkg::MAG_W-1:0]    op_a,
    input  logic [nsdb_pkg::MAG_W-1:0]    op_b,
    output nsdb_pkg::sq_stat_t            stat,
    output logic [nsdb_pkg::SQ_W-1:0]     sum
);

    logic                        s1_valid_reg;
    logic                        out_valid_reg;
    logic [nsdb_pkg::SQ_W-1:0]   sq_a_reg;
    logic [nsdb_pkg::SQ_W-1:0]   sq_b_reg;
    logic [nsdb_pkg::SQ_W-1:0]   sq_a_next;
    logic [nsdb_pkg::SQ_W-1:0]   sq_b_next;
    logic [nsdb_pkg::SQ_W-1:0]   sum_reg;
    logic [nsdb_pkg::SQ_W-1:0]   sum_next;

    assign sq_a_next = op_a * op_a;
    assign sq_b_next = op_b * op_b;
    assign sum_next  = sq_a_reg + sq_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_a_reg <= sq_a_next;
        sq_b_reg <= sq_b_next;
        sum_reg  <= sum_next;
    end

    assign stat.s1_valid  = s1_valid_reg;
    assign stat.out_valid = out_valid_reg;
    assign sum            = sum_reg;

endmodule

[hdl/nsdb_counters.sv]
// ----------------------------------------------------------------------------
// nsdb_counters
// Saturating per-bin and query counters.
// ----------------------------------------------------------------------------
module nsdb_counters (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 upd,
    input  nsdb_pkg::bin_t       bin,
    output nsdb_pkg::counts_t    counts
);

    nsdb_pkg::counts_t counts_reg;
    nsdb_pkg::counts_t counts_next;

    function automatic logic [nsdb_pkg::CNT_W-1:0] sat_inc(
        input logic [nsdb_pkg::CNT_W-1:0] c
    );
        return (c == '1) ? c : c + nsdb_pkg::CNT_W'(1);
    endfunction

    always_comb
    begin
        counts_next = counts_reg;
        if (upd)
        begin
            counts_next.query = sat_inc(counts_reg.query);
            case (bin)
                nsdb_pkg::BIN_NEAR:   counts_next.near   = sat_inc(counts_reg.near);
                nsdb_pkg::BIN_MID:    counts_next.mid    = sat_inc(counts_reg.mid);
                nsdb_pkg::BIN_FAR:    counts_next.far    = sat_inc(counts_reg.far);
                default:              counts_next.beyond = sat_inc(counts_reg.beyond);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
        end
    end

    assign counts = counts_reg;

endmodule

[hdl/nearest_site_distance_binner_unit.sv]
// ----------------------------------------------------------------------------
// nearest_site_distance_binner_unit
// Site table with nearest-site squared distance search and distance binning.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s_axis    in         tuser: cmd; tdata: site_index, coord_x, coord_y
// m_axis    out        tdata: bin, near/mid/far/beyond/query totals
// cfg       in         cfg_we, cfg_index, cfg_data (no read-back)
//
// A load word returns nothing.
// A query scans the first site_count table entries (site_count capped at 1024):
// one table read per cycle feeds the shared squaring unit, which then squares the limits.
// No word is taken while a query runs; a finished result waits in the output register
// while loads proceed, and the next query stalls at its last step until it is taken.
// Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`include "nearest_site_distance_binner_unit_assert.svh"

module nearest_site_distance_binner_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // site_index, coord_x, coord_y, zero pad
    input  logic [nsdb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // bin, near_total, mid_total, far_total, beyond_total, query_total, zero pad
    output logic [nsdb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [nsdb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nsdb_pkg::CFG_W-1:0]            cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_LIM   = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_UPD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    localparam logic [1:0] LIM_DONE = 2'd3;
    localparam logic [1:0] CAP_LAST = 2'd2;

    state_t                                 state_reg;
    state_t                                 state_next;

    logic [nsdb_pkg::SITE_COUNT_W-1:0]      site_count_reg;
    logic [nsdb_pkg::LIMIT_W-1:0]           near_limit_reg;
    logic [nsdb_pkg::LIMIT_W-1:0]           mid_limit_reg;
    logic [nsdb_pkg::LIMIT_W-1:0]           far_limit_reg;

    logic [nsdb_pkg::COORD_W-1:0]           px_reg;
    logic [nsdb_pkg::COORD_W-1:0]           py_reg;
    logic [nsdb_pkg::SCAN_CW-1:0]           n_reg;
    logic [nsdb_pkg::SCAN_CW-1:0]           n_next;
    logic [nsdb_pkg::SCAN_CW-1:0]           scan_cnt_reg;
    logic [nsdb_pkg::SCAN_CW-1:0]           scan_cnt_inc;
    logic                                   rd_vld_reg;
    logic [nsdb_pkg::SQ_W-1:0]              best_reg;
    logic [1:0]                             lim_sel_reg;
    logic [1:0]                             cap_cnt_reg;
    logic [nsdb_pkg::SQ_W-1:0]              lim0_reg;
    logic [nsdb_pkg::SQ_W-1:0]              lim1_reg;
    logic [nsdb_pkg::SQ_W-1:0]              lim2_reg;
    nsdb_pkg::bin_t                         bin_reg;
    nsdb_pkg::bin_t                         bin_next;
    logic                                   m_tvalid_reg;
    logic [nsdb_pkg::OUT_TDATA_W-1:0]       m_tdata_reg;

    logic                                   in_acc;
    logic                                   is_query;
    logic                                   out_free;
    logic                                   ram_we;
    logic                                   ram_re;
    logic [2*nsdb_pkg::COORD_W-1:0]         ram_rdata;
    logic [nsdb_pkg::COORD_W-1:0]           site_x;
    logic [nsdb_pkg::COORD_W-1:0]           site_y;
    logic [nsdb_pkg::MAG_W-1:0]             dx_pos;
    logic [nsdb_pkg::MAG_W-1:0]             dx_neg;
    logic [nsdb_pkg::MAG_W-1:0]             dy_pos;
    logic [nsdb_pkg::MAG_W-1:0]             dy_neg;
    logic                                   sq_in_valid;
    logic [nsdb_pkg::MAG_W-1:0]             sq_op_a;
    logic [nsdb_pkg::MAG_W-1:0]             sq_op_b;
    logic [nsdb_pkg::LIMIT_W-1:0]           lim_sel_val;
    nsdb_pkg::sq_stat_t                     sq_stat;
    logic [nsdb_pkg::SQ_W-1:0]              sq_sum;
    logic                                   cnt_upd;
    nsdb_pkg::counts_t                      counts;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_query      = (s_axis_tuser == nsdb_pkg::CMD_QUERY);
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= '0;
            near_limit_reg <= nsdb_pkg::LIMIT_W'(1000);
            mid_limit_reg  <= nsdb_pkg::LIMIT_W'(2000);
            far_limit_reg  <= nsdb_pkg::LIMIT_W'(5000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsdb_pkg::CFG_SITE_COUNT:
                    site_count_reg <= cfg_data[nsdb_pkg::SITE_COUNT_W-1:0];
                nsdb_pkg::CFG_NEAR_LIMIT: near_limit_reg <= cfg_data;
                nsdb_pkg::CFG_MID_LIMIT:  mid_limit_reg  <= cfg_data;
                nsdb_pkg::CFG_FAR_LIMIT:  far_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(site_count_reg) > 32'(nsdb_pkg::MAX_SITES))
        begin
            n_next = nsdb_pkg::SCAN_CW'(nsdb_pkg::MAX_SITES);
        end
        else
        begin
            n_next = nsdb_pkg::SCAN_CW'(site_count_reg);
        end
    end

    assign ram_we = in_acc && !is_query;
    assign ram_re = (state_reg == ST_SCAN);

    nsdb_site_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_axis_tdata[nsdb_pkg::SITE_AW-1:0]),
        .wdata (s_axis_tdata[nsdb_pkg::IN_USED_W-1:nsdb_pkg::SITE_AW]),
        .re    (ram_re),
        .raddr (scan_cnt_reg[nsdb_pkg::SITE_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign site_x = ram_rdata[nsdb_pkg::COORD_W-1:0];
    assign site_y = ram_rdata[2*nsdb_pkg::COORD_W-1:nsdb_pkg::COORD_W];

    assign dx_pos = {px_reg[nsdb_pkg::COORD_W-1], px_reg}
                  - {site_x[nsdb_pkg::COORD_W-1], site_x};
    assign dx_neg = {site_x[nsdb_pkg::COORD_W-1], site_x}
                  - {px_reg[nsdb_pkg::COORD_W-1], px_reg};
    assign dy_pos = {py_reg[nsdb_pkg::COORD_W-1], py_reg}
                  - {site_y[nsdb_pkg::COORD_W-1], site_y};
    assign dy_neg = {site_y[nsdb_pkg::COORD_W-1], site_y}
                  - {py_reg[nsdb_pkg::COORD_W-1], py_reg};

    always_comb
    begin
        case (lim_sel_reg)
            2'd0:    lim_sel_val = near_limit_reg;
            2'd1:    lim_sel_val = mid_limit_reg;
            default: lim_sel_val = far_limit_reg;
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_LIM)
        begin
            sq_in_valid = (lim_sel_reg != LIM_DONE);
            sq_op_a     = nsdb_pkg::MAG_W'(lim_sel_val);
            sq_op_b     = '0;
        end
        else
        begin
            sq_in_valid = rd_vld_reg;
            sq_op_a     = dx_pos[nsdb_pkg::MAG_W-1] ? dx_neg : dx_pos;
            sq_op_b     = dy_pos[nsdb_pkg::MAG_W-1] ? dy_neg : dy_pos;
        end
    end

    nsdb_sq_unit u_sq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sq_in_valid),
        .op_a     (sq_op_a),
        .op_b     (sq_op_b),
        .stat     (sq_stat),
        .sum      (sq_sum)
    );

    always_comb
    begin
        if (best_reg <= lim0_reg)
        begin
            bin_next = nsdb_pkg::BIN_NEAR;
        end
        else if (best_reg <= lim1_reg)
        begin
            bin_next = nsdb_pkg::BIN_MID;
        end
        else if (best_reg <= lim2_reg)
        begin
            bin_next = nsdb_pkg::BIN_FAR;
        end
        else
        begin
            bin_next = nsdb_pkg::BIN_BEYOND;
        end
    end

    assign cnt_upd = (state_reg == ST_UPD);

    nsdb_counters u_cnt (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (cnt_upd),
        .bin    (bin_reg),
        .counts (counts)
    );

    assign scan_cnt_inc = scan_cnt_reg + nsdb_pkg::SCAN_CW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    state_next = (n_next == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_inc == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !sq_stat.s1_valid)
                begin
                    state_next = ST_LIM;
                end
            end
            ST_LIM:
            begin
                if (sq_stat.out_valid && cap_cnt_reg == CAP_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_vld_reg   <= 1'b0;
            scan_cnt_reg <= '0;
            lim_sel_reg  <= '0;
            cap_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= ram_re;
            if (in_acc && is_query)
            begin
                scan_cnt_reg <= '0;
                lim_sel_reg  <= '0;
                cap_cnt_reg  <= '0;
            end
            if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_inc;
            end
            if (state_reg == ST_LIM)
            begin
                if (lim_sel_reg != LIM_DONE)
                begin
                    lim_sel_reg <= lim_sel_reg + 2'd1;
                end
                if (sq_stat.out_valid)
                begin
                    cap_cnt_reg <= cap_cnt_reg + 2'd1;
                end
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && is_query)
        begin
            px_reg   <= s_axis_tdata[nsdb_pkg::SITE_AW +: nsdb_pkg::COORD_W];
            py_reg   <= s_axis_tdata[nsdb_pkg::SITE_AW + nsdb_pkg::COORD_W +: nsdb_pkg::COORD_W];
            n_reg    <= n_next;
            best_reg <= '1;
        end
        else if (sq_stat.out_valid && state_reg != ST_LIM && sq_sum < best_reg)
        begin
            best_reg <= sq_sum;
        end
        if (state_reg == ST_LIM && sq_stat.out_valid)
        begin
            lim0_reg <= lim1_reg;
            lim1_reg <= lim2_reg;
            lim2_reg <= sq_sum;
        end
        if (state_reg == ST_CMP)
        begin
            bin_reg <= bin_next;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= {{(nsdb_pkg::OUT_TDATA_W - nsdb_pkg::OUT_USED_W){1'b0}},
                            counts.query, counts.beyond, counts.far,
                            counts.mid, counts.near, bin_reg};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    `NSDB_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN,
        scan_cnt_reg < n_reg, "scan address reached the site count")
    `NSDB_ASSERT_IMP(a_lim_no_scan, clk, rst_n, state_reg == ST_LIM,
        !rd_vld_reg && sq_stat.out_valid == (cap_cnt_reg != 2'd0 || sq_stat.out_valid),
        "site data in flight while limits are squared")
    `NSDB_ASSERT_NXT(a_query_count, clk, rst_n, state_reg == ST_UPD && counts.query != '1,
        counts.query == $past(counts.query) + 32'd1, "query counter did not advance")
    `NSDB_ASSERT_NXT(a_out_load, clk, rst_n, state_reg == ST_OUT && out_free,
        m_tvalid_reg && m_tdata_reg[nsdb_pkg::BIN_W-1:0] == $past(bin_reg),
        "result word not presented with its bin")

endmodule

[test/nearest_site_distance_binner_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest site distance binner checker
// Watches the input word, configuration and result word channels of the
// binner. It keeps its own site table, limits and bin totals, works out the
// bin and the totals of every accepted query, and compares each result word
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module nearest_site_distance_binner_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // site_index, coord_x, coord_y, zero pad
    input  logic [nsdb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // cmd
    input  logic                                  s_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // bin, near_total, mid_total, far_total, beyond_total, query_total, zero pad
    input  logic [nsdb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [nsdb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nsdb_pkg::CFG_W-1:0]            cfg_data,
    output int                                    open_results,
    output int                                    fail_count
);

    import nsdb_pkg::*;

    localparam logic [LIMIT_W-1:0] NEAR_RESET = 23'd1000;
    localparam logic [LIMIT_W-1:0] MID_RESET  = 23'd2000;
    localparam logic [LIMIT_W-1:0] FAR_RESET  = 23'd5000;

    typedef struct packed {
        counts_t totals;
        bin_t    bin;
    } tally_t;

    logic signed [COORD_W-1:0] site_x [MAX_SITES];
    logic signed [COORD_W-1:0] site_y [MAX_SITES];
    logic [SITE_COUNT_W-1:0]   scan_count;
    logic [LIMIT_W-1:0]        near_lim;
    logic [LIMIT_W-1:0]        mid_lim;
    logic [LIMIT_W-1:0]        far_lim;
    counts_t                   totals;
    tally_t                    predicted_tallies [$];
    int                        errors = 0;

    function automatic bin_t nearest_bin(logic signed [COORD_W-1:0] px,
                                         logic signed [COORD_W-1:0] py);
        longint best;
        longint dx;
        longint dy;
        longint d2;
        int     n;
        int     i;
        bit     found;
        n = (scan_count > MAX_SITES) ? MAX_SITES : int'(scan_count);
        found = 1'b0;
        best = 0;
        for (i = 0; i < n; i++)
        begin
            dx = longint'(px) - longint'(site_x[i]);
            dy = longint'(py) - longint'(site_y[i]);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            d2 = dx * dx + dy * dy;
            if (!found || d2 < best)
            begin
                best = d2;
                found = 1'b1;
            end
        end
        if (!found)
            return BIN_BEYOND;
        if (best <= longint'(near_lim) * longint'(near_lim))
            return BIN_NEAR;
        if (best <= longint'(mid_lim) * longint'(mid_lim))
            return BIN_MID;
        if (best <= longint'(far_lim) * longint'(far_lim))
            return BIN_FAR;
        return BIN_BEYOND;
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tally_t                    want;
        tally_t                    made;
        logic [SITE_AW-1:0]        slot;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        if (!rst_n)
        begin
            scan_count = '0;
            near_lim = NEAR_RESET;
            mid_lim = MID_RESET;
            far_lim = FAR_RESET;
            totals = '0;
            predicted_tallies.delete();
            open_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (predicted_tallies.size() == 0)
                begin
                    $error("result word arrived with no query waiting");
                    errors++;
                end
                else
                begin
                    want = predicted_tallies.pop_front();
                    check_field("bin", CNT_W'(want.bin), CNT_W'(m_axis_tdata[BIN_W-1:0]));
                    check_field("near_total", want.totals.near,
                                m_axis_tdata[BIN_W +: CNT_W]);
                    check_field("mid_total", want.totals.mid,
                                m_axis_tdata[BIN_W + CNT_W +: CNT_W]);
                    check_field("far_total", want.totals.far,
                                m_axis_tdata[BIN_W + 2 * CNT_W +: CNT_W]);
                    check_field("beyond_total", want.totals.beyond,
                                m_axis_tdata[BIN_W + 3 * CNT_W +: CNT_W]);
                    check_field("query_total", want.totals.query,
                                m_axis_tdata[BIN_W + 4 * CNT_W +: CNT_W]);
                end
            end

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SITE_COUNT: scan_count = cfg_data[SITE_COUNT_W-1:0];
                    CFG_NEAR_LIMIT: near_lim = cfg_data[LIMIT_W-1:0];
                    CFG_MID_LIMIT:  mid_lim = cfg_data[LIMIT_W-1:0];
                    CFG_FAR_LIMIT:  far_lim = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                slot = s_axis_tdata[SITE_AW-1:0];
                px = s_axis_tdata[SITE_AW +: COORD_W];
                py = s_axis_tdata[SITE_AW + COORD_W +: COORD_W];
                if (cmd_t'(s_axis_tuser) == CMD_LOAD)
                begin
                    site_x[slot] = px;
                    site_y[slot] = py;
                end
                else
                begin
                    made.bin = nearest_bin(px, py);
                    case (made.bin)
                        BIN_NEAR: totals.near = bump(totals.near);
                        BIN_MID:  totals.mid = bump(totals.mid);
                        BIN_FAR:  totals.far = bump(totals.far);
                        default:  totals.beyond = bump(totals.beyond);
                    endcase
                    totals.query = bump(totals.query);
                    made.totals = totals;
                    predicted_tallies.insert(predicted_tallies.size(), made);
                end
            end
            open_results <= predicted_tallies.size();
        end
        fail_count <= errors;
    end

endmodule

[test/nearest_site_distance_binner_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest site distance binner testbench
// Loads sites and sends query points to the binner while the checker beside
// it predicts every result. A directed opening covers the bin bounds, the
// coordinate extremes, an empty table and unordered limits; random phases
// follow with new settings, random idling on both sides and one long output
// hold-off; the run ends with a scan over the whole filled front of the table.
// ----------------------------------------------------------------------------
module nearest_site_distance_binner_unit_tb;

    import nsdb_pkg::*;

    localparam int COORD_MAX       = 8388607;
    localparam int COORD_MIN       = -8388608;
    localparam int LIMIT_MAX       = 8388607;
    localparam int RANDOM_ITEMS    = 530;
    localparam int QUIET_TAIL      = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT  = 8000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // site_index, coord_x, coord_y, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // cmd
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // bin, near_total, mid_total, far_total, beyond_total, query_total, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    int                     open_results;
    int                     fail_count;

    bit                     idling;
    bit                     hold_off_pending;
    int                     placed_x [MAX_SITES];
    int                     placed_y [MAX_SITES];
    bit                     placed [MAX_SITES];
    int                     filled;

    nearest_site_distance_binner_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    nearest_site_distance_binner_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .open_results  (open_results),
        .fail_count    (fail_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int any_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom());
        return int'(v);
    endfunction

    function automatic int aim(int center, int reach);
        int v;
        v = center + int'($urandom_range(0, 2 * reach)) - reach;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    task automatic send_word(cmd_t c, int idx, int x, int y);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c;
        s_axis_tdata <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, y[COORD_W-1:0], x[COORD_W-1:0],
                         idx[SITE_AW-1:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic place_site(int idx, int x, int y);
        send_word(CMD_LOAD, idx, x, y);
        placed_x[idx] = x;
        placed_y[idx] = y;
        placed[idx] = 1'b1;
        while (filled < MAX_SITES && placed[filled])
            filled++;
    endtask

    task automatic ask(int x, int y);
        send_word(CMD_QUERY, int'($urandom_range(0, MAX_SITES - 1)), x, y);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(int count, int near_v, int mid_v, int far_v);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SITE_COUNT;
        cfg_data <= count[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_NEAR_LIMIT;
        cfg_data <= near_v[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_MID_LIMIT;
        cfg_data <= mid_v[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_FAR_LIMIT;
        cfg_data <= far_v[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int count;
        int near_v;
        int mid_v;
        int far_v;
        int span;
        int reach;
        int lim;
        int slot;
        int j;
        int random_sent;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_LOAD;
        cfg_we = 1'b0;
        cfg_index = CFG_SITE_COUNT;
        cfg_data = '0;
        idling = 1'b0;
        hold_off_pending = 1'b0;
        filled = 0;
        random_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table first: every point lands in the last bin.
        ask(0, 0);
        ask(COORD_MAX, COORD_MIN);
        place_site(0, 0, 0);
        place_site(1, COORD_MAX, COORD_MAX);
        place_site(2, COORD_MIN, COORD_MIN);
        place_site(3, 0, 100000);
        settle();
        set_registers(4, 1000, 2000, 5000);
        ask(1000, 0);
        ask(1001, 0);
        ask(2000, 0);
        ask(2001, 0);
        ask(5000, 0);
        ask(5001, 0);
        ask(COORD_MAX, COORD_MAX);
        ask(COORD_MIN, COORD_MIN);
        ask(COORD_MAX, COORD_MIN);
        ask(-3, -4);
        settle();
        // Limits out of order: the first bound that holds decides.
        set_registers(4, 0, LIMIT_MAX, 0);
        ask(0, 0);
        ask(1, 0);
        ask(COORD_MAX, COORD_MIN);
        settle();
        set_registers(4, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
        ask(COORD_MAX, 0);
        ask(COORD_MAX, COORD_MIN);
        settle();

        // Output held off while queries keep coming, so the block backs up.
        idling = 1'b1;
        set_registers(3, 50000, 200000, 1000000);
        hold_off_pending = 1'b1;
        repeat (12)
        begin
            j = $urandom_range(0, 2);
            ask(aim(placed_x[j], 60000), aim(placed_y[j], 60000));
        end
        settle();

        while (random_sent < RANDOM_ITEMS)
        begin
            idling = (random_sent + QUIET_TAIL < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
            j = $urandom_range(0, 9);
            if (filled == 0 || j == 0)
                count = 0;
            else if (j == 1)
                count = filled;
            else
                count = $urandom_range(1, (filled < 24) ? filled : 24);
            case ($urandom_range(0, 2))
                0: span = 50;
                1: span = 20000;
                default: span = LIMIT_MAX;
            endcase
            if ($urandom_range(0, 5) == 0)
            begin
                near_v = $urandom_range(0, 1) ? LIMIT_MAX : 0;
                mid_v = $urandom_range(0, 1) ? LIMIT_MAX : 0;
                far_v = $urandom_range(0, 1) ? LIMIT_MAX : 0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                near_v = $urandom_range(0, span);
                mid_v = $urandom_range(0, span);
                far_v = $urandom_range(0, span);
            end
            else
            begin
                near_v = $urandom_range(0, span);
                mid_v = near_v + int'($urandom_range(0, span));
                far_v = mid_v + int'($urandom_range(0, span));
                if (mid_v > LIMIT_MAX)
                    mid_v = LIMIT_MAX;
                if (far_v > LIMIT_MAX)
                    far_v = LIMIT_MAX;
            end
            settle();
            set_registers(count, near_v, mid_v, far_v);
            repeat ($urandom_range(10, 40))
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    if (filled < MAX_SITES && $urandom_range(0, 1) == 1)
                        slot = filled;
                    else
                        slot = $urandom_range(0, MAX_SITES - 1);
                    if ($urandom_range(0, 1) == 1)
                        place_site(slot, any_coord(), any_coord());
                    else
                        place_site(slot, int'($urandom_range(0, 40000)) - 20000,
                                   int'($urandom_range(0, 40000)) - 20000);
                end
                else if (count != 0 && $urandom_range(0, 3) != 0)
                begin
                    j = $urandom_range(0, count - 1);
                    case ($urandom_range(0, 2))
                        0: lim = near_v;
                        1: lim = mid_v;
                        default: lim = far_v;
                    endcase
                    reach = lim + lim / 4 + 1;
                    ask(aim(placed_x[j], reach), aim(placed_y[j], reach));
                end
                else
                    ask(any_coord(), any_coord());
                random_sent++;
            end
        end

        // Longest scan over the filled front of the table.
        idling = 1'b0;
        settle();
        set_registers(filled, 150000, 300000, 600000);
        repeat (3) ask(any_coord(), any_coord());
        settle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
